### rtl/core/mpart_pkg.sv
// ----------------------------------------------------------------------------
// mpart_pkg
// types and constants shared by the peer ack/retry tracker
// ----------------------------------------------------------------------------
package mpart_pkg;

   localparam int MAX_PEERS_DEF = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_ACK  = 2'd2;
   localparam logic [1:0] MODE_NOP  = 2'd3;

   localparam logic [2:0] KIND_IDLE     = 3'd0;
   localparam logic [2:0] KIND_SEND     = 3'd1;
   localparam logic [2:0] KIND_ACK_OK   = 3'd2;
   localparam logic [2:0] KIND_ACK_BAD  = 3'd3;
   localparam logic [2:0] KIND_ACK_UNK  = 3'd4;
   localparam logic [2:0] KIND_LOAD     = 3'd5;

   localparam logic [2:0] ST_PENDING  = 3'd0;
   localparam logic [2:0] ST_RETRYING = 3'd1;
   localparam logic [2:0] ST_AWAITING = 3'd2;
   localparam logic [2:0] ST_SUCCESS  = 3'd3;
   localparam logic [2:0] ST_FAILED   = 3'd4;

   localparam logic [1:0] CSR_DEVICE_COUNT = 2'd0;
   localparam logic [1:0] CSR_RETRY_IVL    = 2'd1;
   localparam logic [1:0] CSR_ACK_TIMEOUT  = 2'd2;
   localparam logic [1:0] CSR_MAX_ATTEMPTS = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  slot;
      logic [7:0]  device_id;
      logic [31:0] time_ms;
      logic [31:0] time_us;
      logic [31:0] echoed_stamp;
      logic [31:0] rx_proc_us;
      logic [31:0] rtt_us;
      logic [31:0] delay_time_ms;
      logic [31:0] play_time_ms;
      logic [31:0] button_us;
      logic        send_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  peer_id;
      logic [31:0] cmd_delay_ms;
      logic [31:0] cmd_play_ms;
      logic [31:0] cmd_button_us;
      logic [31:0] prior_rtt_us;
      logic [31:0] prior_rx_us;
      logic [31:0] tx_stamp;
      logic        all_done;
      logic [15:0] ack_total;
   } rsp_type;

   // one table entry as stored in the memory
   typedef struct packed {
      logic [7:0]  ident;
      logic [2:0]  status;
      logic [7:0]  attempts;
      logic [31:0] last_send_ms;
      logic [31:0] deadline_ms;
      logic [31:0] sent_us;
      logic [31:0] delay_ms;
      logic [31:0] play_ms;
      logic [31:0] button_us;
      logic [31:0] rtt_us;
      logic [31:0] rx_us;
      logic [15:0] succ;
   } entry_type;

   typedef struct packed {
      logic [15:0] retry_ivl;
      logic [15:0] ack_timeout;
      logic [7:0]  max_attempts;
   } cfg_type;

endpackage

### rtl/core/mpart_table.sv
// ----------------------------------------------------------------------------
// mpart_table
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module mpart_table #(
   parameter int MAX_PEERS = mpart_pkg::MAX_PEERS_DEF,
   localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  mpart_pkg::entry_type  wr_data,
   input  logic [AW-1:0]         rd_addr,
   output mpart_pkg::entry_type  rd_data
);

   mpart_pkg::entry_type mem [MAX_PEERS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/core/multi_peer_ack_retry_tracker.sv
// ----------------------------------------------------------------------------
// multi_peer_ack_retry_tracker
// stop-and-wait ack/retry tracker over a table of peer entries
// ----------------------------------------------------------------------------
// timing: a load offers its result in the cycle after acceptance; a tick or an ack
//   walks the entries one at a time, each through a read state and then an
//   evaluate-and-write-back state, and offers its result on a hit or when the
//   walk runs off the end of the entries in use
// flow: one transaction at a time; the next is accepted only once the result
//   has left and the block is back in idle
// reset: synchronous active high; state, csr and latest-value registers reset,
//   payload and walk registers and the entry table are not cleared (entries are undefined until loaded)
module multi_peer_ack_retry_tracker #(
   parameter int MAX_PEERS = mpart_pkg::MAX_PEERS_DEF,
   localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1,
   localparam int CW = $clog2(MAX_PEERS + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  mpart_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output mpart_pkg::rsp_type               rsp_data,
   input  logic                             csr_wr_en,
   input  logic [mpart_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mpart_pkg::CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_EVAL  = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   mpart_pkg::req_type   req_ff;
   logic [4:0]           dev_count_ff;
   mpart_pkg::cfg_type   cfg_ff;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 done_ff, done_in;
   mpart_pkg::rsp_type   rsp_ff, rsp_in;
   logic [31:0]          latest_rtt_ff, latest_rx_ff;
   logic                 lat_we;

   logic                 wr_en;
   mpart_pkg::entry_type wr_data, rd_data, e;
   logic [CW-1:0]        used;
   logic [31:0]          elapsed;
   logic                 pending, awaiting;

   // entries in use, clipped to the table depth
   always_comb begin
      if (32'(dev_count_ff) > 32'(MAX_PEERS)) begin
         used = CW'(MAX_PEERS);
      end else begin
         used = CW'(dev_count_ff);
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   mpart_table #(.MAX_PEERS(MAX_PEERS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (state_ff == S_IDLE ? AW'(req_data.slot) : idx_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign e        = rd_data;
   assign elapsed  = req_ff.time_ms - e.last_send_ms;
   assign pending  = (e.status == mpart_pkg::ST_PENDING) ||
                     (e.status == mpart_pkg::ST_RETRYING);
   assign awaiting = (e.status == mpart_pkg::ST_AWAITING);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      done_in  = done_ff;
      rsp_in   = rsp_ff;
      wr_en    = 1'b0;
      wr_data  = e;
      lat_we   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in  = '0;
            done_in = 1'b1;
            rsp_in  = '0;
            // load writes the entry straight from the request
            wr_data.ident        = req_data.device_id;
            wr_data.status       = mpart_pkg::ST_PENDING;
            wr_data.attempts     = '0;
            wr_data.last_send_ms = '0;
            wr_data.deadline_ms  = '0;
            wr_data.sent_us      = '0;
            wr_data.delay_ms     = req_data.delay_time_ms;
            wr_data.play_ms      = req_data.play_time_ms;
            wr_data.button_us    = req_data.button_us;
            wr_data.rtt_us       = req_data.rtt_us;
            wr_data.rx_us        = req_data.rx_proc_us;
            wr_data.succ         = '0;
            if (req_valid) begin
               priority case (req_data.mode)
                  mpart_pkg::MODE_LOAD: begin
                     if (32'(req_data.slot) < 32'(MAX_PEERS)) begin
                        wr_en          = 1'b1;
                        rsp_in.kind    = mpart_pkg::KIND_LOAD;
                        rsp_in.peer_id = req_data.device_id;
                     end
                     state_in = S_RESP;
                  end
                  mpart_pkg::MODE_TICK, mpart_pkg::MODE_ACK: state_in = S_READ;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_READ: begin
            if (idx_ff >= used) begin
               // walk ended without a hit
               if (req_ff.mode == mpart_pkg::MODE_TICK) begin
                  rsp_in.all_done = done_ff;
               end else begin
                  rsp_in.kind    = mpart_pkg::KIND_ACK_UNK;
                  rsp_in.peer_id = req_ff.device_id;
               end
               state_in = S_RESP;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_READ;
            idx_in   = idx_ff + 1'b1;
            if (req_ff.mode == mpart_pkg::MODE_TICK) begin
               if (e.status != mpart_pkg::ST_SUCCESS && e.status != mpart_pkg::ST_FAILED) begin
                  done_in = 1'b0;
               end
               if (pending && (elapsed >= 32'(cfg_ff.retry_ivl) || e.attempts == '0)) begin
                  rsp_in.kind          = mpart_pkg::KIND_SEND;
                  rsp_in.peer_id       = e.ident;
                  rsp_in.cmd_delay_ms  = e.delay_ms;
                  rsp_in.cmd_play_ms   = e.play_ms;
                  rsp_in.cmd_button_us = e.button_us;
                  rsp_in.prior_rtt_us  = e.rtt_us;
                  rsp_in.prior_rx_us   = e.rx_us;
                  rsp_in.tx_stamp      = req_ff.time_us;
                  rsp_in.ack_total     = e.succ;
                  if (req_ff.send_ok) begin
                     wr_en = 1'b1;
                     if (e.attempts != 8'hFF) wr_data.attempts = e.attempts + 8'd1;
                     wr_data.last_send_ms = req_ff.time_ms;
                     wr_data.deadline_ms  = req_ff.time_ms + 32'(cfg_ff.ack_timeout);
                     wr_data.sent_us      = req_ff.time_us;
                     wr_data.status       = mpart_pkg::ST_AWAITING;
                  end
                  state_in = S_RESP;
               end else if (awaiting && req_ff.time_ms > e.deadline_ms) begin
                  wr_en          = 1'b1;
                  wr_data.status = (e.attempts >= cfg_ff.max_attempts) ?
                                   mpart_pkg::ST_FAILED : mpart_pkg::ST_RETRYING;
               end
            end else if (e.ident == req_ff.device_id) begin
               rsp_in.peer_id   = req_ff.device_id;
               rsp_in.tx_stamp  = e.sent_us;
               state_in         = S_RESP;
               if (awaiting && req_ff.echoed_stamp == e.sent_us) begin
                  wr_en               = 1'b1;
                  lat_we              = 1'b1;
                  wr_data.status      = mpart_pkg::ST_SUCCESS;
                  wr_data.succ        = e.succ + 16'd1;
                  wr_data.rtt_us      = req_ff.time_us - req_ff.echoed_stamp;
                  wr_data.rx_us       = req_ff.rx_proc_us;
                  rsp_in.kind         = mpart_pkg::KIND_ACK_OK;
                  rsp_in.prior_rtt_us = wr_data.rtt_us;
                  rsp_in.prior_rx_us  = req_ff.rx_proc_us;
                  rsp_in.ack_total    = wr_data.succ;
               end else begin
                  rsp_in.kind         = mpart_pkg::KIND_ACK_BAD;
                  rsp_in.prior_rtt_us = e.rtt_us;
                  rsp_in.prior_rx_us  = e.rx_us;
                  rsp_in.ack_total    = e.succ;
               end
            end
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         dev_count_ff  <= '0;
         cfg_ff        <= '{retry_ivl: 16'd100, ack_timeout: 16'd50, max_attempts: 8'd3};
         latest_rtt_ff <= '0;
         latest_rx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (lat_we) begin
            latest_rtt_ff <= wr_data.rtt_us;
            latest_rx_ff  <= wr_data.rx_us;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               mpart_pkg::CSR_DEVICE_COUNT: dev_count_ff <= csr_wdata[4:0];
               mpart_pkg::CSR_RETRY_IVL:    cfg_ff.retry_ivl <= csr_wdata;
               mpart_pkg::CSR_ACK_TIMEOUT:  cfg_ff.ack_timeout <= csr_wdata;
               mpart_pkg::CSR_MAX_ATTEMPTS: cfg_ff.max_attempts <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
      // payload and walk registers
      idx_ff  <= idx_in;
      done_ff <= done_in;
      rsp_ff  <= rsp_in;
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
   end

   // a result is only offered at the end of a walk, a load or a no-op
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_READ || $past(state_ff) == S_EVAL ||
                            $past(state_ff) == S_IDLE))
      else $error("result offered out of sequence");

   // no new transaction while a result waits
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   // walk never runs past the table
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (idx_ff < used))
      else $error("entry walk out of range");

endmodule

### verif/multi_peer_ack_retry_tracker_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_peer_ack_retry_tracker_chk
// watches the request, response and csr ports, predicts every response from
// its own copy of the peer table and compares field by field, in order
// ----------------------------------------------------------------------------
module multi_peer_ack_retry_tracker_chk (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  mpart_pkg::req_type               req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  mpart_pkg::rsp_type               rsp_data,
   input  logic                             csr_wr_en,
   input  logic [mpart_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mpart_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                               fail_count,
   output int                               pending_count,
   output int                               sends_seen,
   output int                               acks_ok_seen
);

   logic [4:0]           dev_count;
   logic [15:0]          retry_ivl;
   logic [15:0]          ack_tmo;
   logic [7:0]           max_att;
   mpart_pkg::entry_type peer_tab [mpart_pkg::MAX_PEERS_DEF];
   mpart_pkg::rsp_type   expected_rsp_q [$];

   assign pending_count = expected_rsp_q.size();

   function automatic mpart_pkg::rsp_type track_step(mpart_pkg::req_type rq);
      mpart_pkg::rsp_type r;
      int n;
      logic done;
      r = '0;
      n = (dev_count > mpart_pkg::MAX_PEERS_DEF) ? mpart_pkg::MAX_PEERS_DEF : int'(dev_count);
      case (rq.mode)
         mpart_pkg::MODE_LOAD: begin
            peer_tab[rq.slot] = '0;
            peer_tab[rq.slot].ident = rq.device_id;
            peer_tab[rq.slot].status = mpart_pkg::ST_PENDING;
            peer_tab[rq.slot].delay_ms = rq.delay_time_ms;
            peer_tab[rq.slot].play_ms = rq.play_time_ms;
            peer_tab[rq.slot].button_us = rq.button_us;
            peer_tab[rq.slot].rtt_us = rq.rtt_us;
            peer_tab[rq.slot].rx_us = rq.rx_proc_us;
            r.kind = mpart_pkg::KIND_LOAD;
            r.peer_id = rq.device_id;
         end
         mpart_pkg::MODE_TICK: begin
            done = 1'b1;
            for (int i = 0; i < n; i++) begin
               if (peer_tab[i].status == mpart_pkg::ST_SUCCESS ||
                   peer_tab[i].status == mpart_pkg::ST_FAILED)
                  continue;
               done = 1'b0;
               if (peer_tab[i].status == mpart_pkg::ST_PENDING ||
                   peer_tab[i].status == mpart_pkg::ST_RETRYING) begin
                  if ((rq.time_ms - peer_tab[i].last_send_ms) >= {16'd0, retry_ivl} ||
                      peer_tab[i].attempts == 8'd0) begin
                     r.kind = mpart_pkg::KIND_SEND;
                     r.peer_id = peer_tab[i].ident;
                     r.cmd_delay_ms = peer_tab[i].delay_ms;
                     r.cmd_play_ms = peer_tab[i].play_ms;
                     r.cmd_button_us = peer_tab[i].button_us;
                     r.prior_rtt_us = peer_tab[i].rtt_us;
                     r.prior_rx_us = peer_tab[i].rx_us;
                     r.tx_stamp = rq.time_us;
                     r.ack_total = peer_tab[i].succ;
                     if (rq.send_ok) begin
                        if (peer_tab[i].attempts != 8'hFF)
                           peer_tab[i].attempts = peer_tab[i].attempts + 8'd1;
                        peer_tab[i].last_send_ms = rq.time_ms;
                        peer_tab[i].deadline_ms = rq.time_ms + {16'd0, ack_tmo};
                        peer_tab[i].sent_us = rq.time_us;
                        peer_tab[i].status = mpart_pkg::ST_AWAITING;
                     end
                     return r;
                  end
               end else if (peer_tab[i].status == mpart_pkg::ST_AWAITING) begin
                  if (rq.time_ms > peer_tab[i].deadline_ms)
                     peer_tab[i].status = (peer_tab[i].attempts >= max_att) ?
                                          mpart_pkg::ST_FAILED : mpart_pkg::ST_RETRYING;
               end
            end
            r.all_done = done;
         end
         mpart_pkg::MODE_ACK: begin
            for (int i = 0; i < n; i++) begin
               if (peer_tab[i].ident != rq.device_id) continue;
               r.peer_id = rq.device_id;
               if (peer_tab[i].status == mpart_pkg::ST_AWAITING &&
                   rq.echoed_stamp == peer_tab[i].sent_us) begin
                  peer_tab[i].status = mpart_pkg::ST_SUCCESS;
                  peer_tab[i].succ = peer_tab[i].succ + 16'd1;
                  peer_tab[i].rtt_us = rq.time_us - rq.echoed_stamp;
                  peer_tab[i].rx_us = rq.rx_proc_us;
                  r.kind = mpart_pkg::KIND_ACK_OK;
               end else begin
                  r.kind = mpart_pkg::KIND_ACK_BAD;
               end
               r.prior_rtt_us = peer_tab[i].rtt_us;
               r.prior_rx_us = peer_tab[i].rx_us;
               r.tx_stamp = peer_tab[i].sent_us;
               r.ack_total = peer_tab[i].succ;
               return r;
            end
            r.kind = mpart_pkg::KIND_ACK_UNK;
            r.peer_id = rq.device_id;
         end
         default: ;
      endcase
      return r;
   endfunction

   // one line per mismatch, counted
   task automatic report(string line);
      $display("[%0t] mismatch %s", $time, line);
      fail_count++;
   endtask

   task automatic report_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report($sformatf("%s: got %h expected %h", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      mpart_pkg::rsp_type want;
      if (reset) begin
         dev_count <= 5'd0;
         retry_ivl <= 16'd100;
         ack_tmo   <= 16'd50;
         max_att   <= 8'd3;
         fail_count = 0;
         sends_seen = 0;
         acks_ok_seen = 0;
         foreach (peer_tab[i]) peer_tab[i] = '0;
         expected_rsp_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               mpart_pkg::CSR_DEVICE_COUNT: dev_count <= csr_wdata[4:0];
               mpart_pkg::CSR_RETRY_IVL:    retry_ivl <= csr_wdata;
               mpart_pkg::CSR_ACK_TIMEOUT:  ack_tmo   <= csr_wdata;
               mpart_pkg::CSR_MAX_ATTEMPTS: max_att   <= csr_wdata[7:0];
               default: ;
            endcase
         end
         // response side first, so a transaction predicted this edge never meets it
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               report($sformatf("response with nothing expected, kind %0d", rsp_data.kind));
            end else begin
               want = expected_rsp_q.pop_front();
               report_field("kind", 32'(rsp_data.kind), 32'(want.kind));
               report_field("peer_id", 32'(rsp_data.peer_id), 32'(want.peer_id));
               report_field("cmd_delay_ms", rsp_data.cmd_delay_ms, want.cmd_delay_ms);
               report_field("cmd_play_ms", rsp_data.cmd_play_ms, want.cmd_play_ms);
               report_field("cmd_button_us", rsp_data.cmd_button_us, want.cmd_button_us);
               report_field("prior_rtt_us", rsp_data.prior_rtt_us, want.prior_rtt_us);
               report_field("prior_rx_us", rsp_data.prior_rx_us, want.prior_rx_us);
               report_field("tx_stamp", rsp_data.tx_stamp, want.tx_stamp);
               report_field("all_done", 32'(rsp_data.all_done), 32'(want.all_done));
               report_field("ack_total", 32'(rsp_data.ack_total), 32'(want.ack_total));
               if (want.kind == mpart_pkg::KIND_SEND) sends_seen++;
               if (want.kind == mpart_pkg::KIND_ACK_OK) acks_ok_seen++;
            end
         end
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(track_step(req_data));
      end
   end

endmodule

### verif/multi_peer_ack_retry_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_peer_ack_retry_tracker_tb
// drives loads, ticks and acks through the tracker across several register
// settings, with random idle cycles on both sides and one long response
// hold-off; a checker beside the block predicts and compares every response
// ----------------------------------------------------------------------------
module multi_peer_ack_retry_tracker_tb;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 2 * mpart_pkg::MAX_PEERS_DEF + 8;
   localparam int NUM_PHASES = 6;
   localparam int PHASE_ITEMS = 130;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT_ITEM = 300;
   localparam int QUIET_FROM_ITEM = 420;
   localparam int QUIET_TO_ITEM = 560;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   mpart_pkg::req_type               req_data;
   logic                             rsp_valid;
   logic                             rsp_stall;
   mpart_pkg::rsp_type               rsp_data;
   logic                             csr_wr_en;
   logic [mpart_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mpart_pkg::CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending_count;
   int sends_seen;
   int acks_ok_seen;
   int cycle_count;
   int items_sent;

   // stimulus-side bookkeeping: ids in the table, recent send stamps, clock in ms
   logic [7:0]  slot_ids [mpart_pkg::MAX_PEERS_DEF];
   logic [31:0] recent_stamps [$];
   logic [31:0] now_ms;

   // register settings of the random phases
   logic [15:0] cfg_cnt [NUM_PHASES] = '{16'd16, 16'd31, 16'd5, 16'd1, 16'd0, 16'd16};
   logic [15:0] cfg_ivl [NUM_PHASES] = '{16'd100, 16'd0, 16'd65535, 16'd10, 16'd40, 16'd1};
   logic [15:0] cfg_tmo [NUM_PHASES] = '{16'd50, 16'd0, 16'd65535, 16'd5, 16'd30, 16'd200};
   logic [15:0] cfg_max [NUM_PHASES] = '{16'd3, 16'd1, 16'd255, 16'd2, 16'd4, 16'd8};

   multi_peer_ack_retry_tracker uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   multi_peer_ack_retry_tracker_chk chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .sends_seen    (sends_seen),
      .acks_ok_seen  (acks_ok_seen)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // cycle counter and watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_count);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // receiver: random stall ~9%, a quiet window with no stall, and one long
   // hold-off while the sender keeps offering so the block backs up
   initial begin
      int hold_left;
      bit hold_done;
      rsp_stall = 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (items_sent >= QUIET_FROM_ITEM && items_sent < QUIET_TO_ITEM) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 9);
         end
      end
   end

   // one register write, enable dropped on the following edge
   task automatic csr_write(logic [mpart_pkg::CSR_IDX_W-1:0] idx,
                            logic [mpart_pkg::CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // offer one transaction and hold it until accepted; idle cycles follow at random
   task automatic push_item(mpart_pkg::req_type it, bit quiet);
      req_data  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (it.mode == mpart_pkg::MODE_LOAD) slot_ids[it.slot] = it.device_id;
      if (it.mode == mpart_pkg::MODE_TICK) begin
         recent_stamps.push_back(it.time_us);
         if (recent_stamps.size() > 8) void'(recent_stamps.pop_front());
      end
      if (!quiet) begin
         while ($urandom_range(0, 99) < 9) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // wait for every response and let the block settle before touching registers
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic mpart_pkg::req_type rand_item;
      mpart_pkg::req_type it;
      it = '0;
      it.mode = 2'($urandom_range(0, 3));
      it.slot = 4'($urandom);
      it.device_id = 8'($urandom);
      it.time_ms = $urandom;
      it.time_us = $urandom;
      it.echoed_stamp = $urandom;
      it.rx_proc_us = $urandom;
      it.rtt_us = $urandom;
      it.delay_time_ms = $urandom;
      it.play_time_ms = $urandom;
      it.button_us = $urandom;
      it.send_ok = 1'($urandom);
      return it;
   endfunction

   function automatic mpart_pkg::req_type make_load(logic [3:0] s, logic [7:0] id);
      mpart_pkg::req_type it;
      it = rand_item();
      it.mode = mpart_pkg::MODE_LOAD;
      it.slot = s;
      it.device_id = id;
      return it;
   endfunction

   function automatic mpart_pkg::req_type make_tick(logic ok);
      mpart_pkg::req_type it;
      it = rand_item();
      it.mode = mpart_pkg::MODE_TICK;
      it.time_ms = now_ms;
      it.time_us = now_ms * 1000 + $urandom_range(0, 999);
      it.send_ok = ok;
      return it;
   endfunction

   // mostly acks that echo a recent send stamp from a known peer
   function automatic mpart_pkg::req_type make_ack;
      mpart_pkg::req_type it;
      it = rand_item();
      it.mode = mpart_pkg::MODE_ACK;
      if ($urandom_range(0, 99) < 85) it.device_id = slot_ids[$urandom_range(0, 15)];
      if (recent_stamps.size() != 0 && $urandom_range(0, 99) < 75)
         it.echoed_stamp = recent_stamps[$urandom_range(0, recent_stamps.size() - 1)];
      it.time_us = it.echoed_stamp + $urandom_range(0, 20000);
      return it;
   endfunction

   initial begin
      mpart_pkg::req_type it;
      int                 roll;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      items_sent = 0;
      now_ms = 32'hFFFF_FF80;   // start just below the ms wrap
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fill the table while no entry is in use, extremes of the fields
      for (int s = 0; s < mpart_pkg::MAX_PEERS_DEF; s++) begin
         it = make_load(4'(s), (s == 15) ? 8'hFF : 8'(s * 16));
         if (s == 0) begin
            it.delay_time_ms = '0; it.play_time_ms = '0; it.button_us = '0;
            it.rtt_us = '0; it.rx_proc_us = '0;
         end else if (s == 15) begin
            it.delay_time_ms = '1; it.play_time_ms = '1; it.button_us = '1;
            it.rtt_us = '1; it.rx_proc_us = '1;
         end
         push_item(it, 1'b0);
      end
      push_item(make_tick(1'b1), 1'b0);          // nothing in use: all done
      drain();
      csr_write(mpart_pkg::CSR_DEVICE_COUNT, 16'd16);
      push_item(make_tick(1'b0), 1'b0);          // send refused by the link
      push_item(make_tick(1'b1), 1'b0);
      it = make_ack();                           // matching ack on slot 0
      it.device_id = 8'h00;
      it.echoed_stamp = recent_stamps[$];
      it.time_us = 32'h0000_0005;                // arrival wraps below the stamp
      push_item(it, 1'b0);
      it.echoed_stamp = ~it.echoed_stamp;        // now a mismatch on a success entry
      push_item(it, 1'b0);
      it.device_id = 8'h7E;                      // id not in the table
      push_item(it, 1'b0);
      it = rand_item();
      it.mode = mpart_pkg::MODE_NOP;             // no operation
      push_item(it, 1'b0);
      now_ms = now_ms + 32'd200;                 // tick across the ms wrap
      push_item(make_tick(1'b1), 1'b0);

      // random phases, one register setting each
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         csr_write(mpart_pkg::CSR_DEVICE_COUNT, cfg_cnt[p]);
         csr_write(mpart_pkg::CSR_RETRY_IVL, cfg_ivl[p]);
         csr_write(mpart_pkg::CSR_ACK_TIMEOUT, cfg_tmo[p]);
         csr_write(mpart_pkg::CSR_MAX_ATTEMPTS, cfg_max[p]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 52) begin
               now_ms = now_ms + $urandom_range(0, 120);
               it = make_tick(($urandom_range(0, 9) != 0));
            end else if (roll < 80) begin
               it = make_ack();
            end else if (roll < 90) begin
               it = make_load(4'($urandom), 8'($urandom));
            end else begin
               it = rand_item();                 // noise, includes no-op mode
            end
            // phase 2 runs with no sender idling at all
            push_item(it, (p == 2));
         end
      end

      drain();
      $display("sent %0d transactions over %0d register settings, %0d sends, %0d acks accepted",
               items_sent, NUM_PHASES + 1, sends_seen, acks_ok_seen);
      $display("included a %0d-cycle response hold-off and wrap of the ms clock", HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
